FILE: rtl/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types, constants and helper functions of the subtractive random
// generator: ring geometry, seeding constants, state codes, modular subtract.
// ----------------------------------------------------------------------------
`default_nettype none

package srg_pkg;

  localparam int unsigned VAL_W       = 30;
  localparam int unsigned RING_LEN    = 55;
  localparam int unsigned IDX_W       = $clog2(RING_LEN);
  localparam int unsigned WARM_DRAWS  = 165;
  localparam int unsigned WARM_W      = $clog2(WARM_DRAWS + 1);

  localparam logic [IDX_W-1:0] LAST_SLOT      = IDX_W'(RING_LEN - 1);
  localparam logic [IDX_W-1:0] SCATTER_STRIDE = IDX_W'(21);
  localparam logic [IDX_W-1:0] SECOND_START   = IDX_W'(24);
  localparam logic [IDX_W-1:0] FIRST_START    = '0;
  localparam logic [WARM_W-1:0] WARM_LAST     = WARM_W'(WARM_DRAWS);

  localparam logic [VAL_W-1:0] MODULUS_RESET  = VAL_W'(1000000007);
  localparam logic [VAL_W-1:0] MODULUS_MIN    = VAL_W'(2);

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_WARM,
    ST_DRAW
  } srg_state_t;

  // circular decrement, 0 (or anything out of range) wraps to the last slot
  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0 || idx > LAST_SLOT) begin
      res = LAST_SLOT;
    end else begin
      res = idx - IDX_W'(1);
    end
    return res;
  endfunction

  // x - y, plus the modulus when it goes negative, kept to VAL_W bits
  function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] x,
                                               input logic [VAL_W-1:0] y,
                                               input logic [VAL_W-1:0] m);
    logic [VAL_W-1:0] diff;
    logic [VAL_W-1:0] res;
    diff = x - y;
    if (x >= y) begin
      res = diff;
    end else begin
      res = diff + m;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/srg_ram.sv
// ----------------------------------------------------------------------------
// srg_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 55
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem_r[rd_addr_a];
      rd_data_b <= mem_r[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/subtractive_random_generator.sv
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Lag 55/24 subtractive generator over a 55-word ring held in a synchronous
// RAM, modulo a programmable modulus. Seeding scatters the ring and runs the
// warm-up draws internally; draws read two entries and write one back.
// ----------------------------------------------------------------------------
//  channel   direction  ports                               role
//  in        sink       in_valid/in_ready, operation, seed  draw or seed request
//  out       source     out_valid/out_ready, random_value   one value per draw
//  cfg       sink       cfg_wr_en, cfg_wr_data              modulus register
//
//  a draw reads the ring, then subtracts and writes back into the RAM
//  a seed runs 55 ring writes, then 165 warm-up draws pipelined
//  at one per cycle through the RAM read and write ports; in_ready is low
//  in_ready also waits while a finished value sits unclaimed in the output
//  register. reset does not sweep the RAM: a flag makes it read as zeros
//  until the first seed has rewritten every entry
// ----------------------------------------------------------------------------
`default_nettype none

module subtractive_random_generator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_operation,
  input  wire logic [srg_pkg::VAL_W-1:0]   in_seed_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [srg_pkg::VAL_W-1:0]   out_random_value,
  input  wire logic                        cfg_wr_en,
  input  wire logic [srg_pkg::VAL_W-1:0]   cfg_wr_data
);

  import srg_pkg::*;

  srg_state_t        state_r, state_nxt;
  logic [VAL_W-1:0]  modulus_r;
  logic [VAL_W-1:0]  eff_mod;
  logic [IDX_W-1:0]  first_r, second_r;
  logic [IDX_W-1:0]  first_dn, second_dn;
  logic [IDX_W-1:0]  fill_cnt_r;
  logic [IDX_W-1:0]  slot_r;
  logic [IDX_W:0]    slot_sum;
  logic [VAL_W-1:0]  prev_r, cur_r;
  logic [WARM_W-1:0] warm_cnt_r;
  logic              pend_r;
  logic [IDX_W-1:0]  wr_addr_r;
  logic              seeded_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;

  logic              in_fire;
  logic              issue;
  logic              load_out;
  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [VAL_W-1:0]  ram_wr_data;
  logic [VAL_W-1:0]  rd_a, rd_b;
  logic [VAL_W-1:0]  ring_a, ring_b;
  logic [VAL_W-1:0]  draw_val;
  logic [VAL_W-1:0]  seed_sat;

  assign eff_mod   = (modulus_r < MODULUS_MIN) ? MODULUS_MIN : modulus_r;
  assign seed_sat  = (in_seed_value > eff_mod - VAL_W'(1)) ? eff_mod - VAL_W'(1)
                                                           : in_seed_value;
  assign first_dn  = step_down(first_r);
  assign second_dn = step_down(second_r);
  assign slot_sum  = {1'b0, slot_r} + {1'b0, SCATTER_STRIDE};

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;

  // unseeded ring reads as zeros
  assign ring_a    = rd_a & {VAL_W{seeded_r}};
  assign ring_b    = rd_b & {VAL_W{seeded_r}};
  assign draw_val  = sub_mod(ring_a, ring_b, eff_mod);

  srg_ram #(
    .WIDTH (VAL_W),
    .DEPTH (RING_LEN)
  ) u_ring (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_en     (issue),
    .rd_addr_a (first_dn),
    .rd_addr_b (second_dn),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_operation == OP_SEED) ? ST_FILL : ST_DRAW;
        end
      end
      ST_FILL: begin
        if (fill_cnt_r == LAST_SLOT) begin
          state_nxt = ST_WARM;
        end
      end
      ST_WARM: begin
        if (warm_cnt_r == WARM_LAST && !pend_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAW: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer: ram read issue, write port mux, output load
  always_comb begin
    issue       = 1'b0;
    load_out    = 1'b0;
    ram_wr_en   = pend_r;
    ram_wr_addr = wr_addr_r;
    ram_wr_data = draw_val;
    case (state_r)
      ST_IDLE: begin
        issue = in_fire && (in_operation == OP_DRAW);
      end
      ST_FILL: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = slot_r;
        ram_wr_data = (fill_cnt_r == '0) ? prev_r : cur_r;
      end
      ST_WARM: begin
        issue = (warm_cnt_r != WARM_LAST);
      end
      ST_DRAW: begin
        load_out = pend_r;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MODULUS_RESET;
      first_r     <= FIRST_START;
      second_r    <= SECOND_START;
      fill_cnt_r  <= '0;
      warm_cnt_r  <= '0;
      pend_r      <= 1'b0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
      if (issue) begin
        first_r  <= first_dn;
        second_r <= second_dn;
      end
      if (in_fire && in_operation == OP_SEED) begin
        fill_cnt_r <= '0;
        seeded_r   <= 1'b1;
      end else if (state_r == ST_FILL) begin
        fill_cnt_r <= fill_cnt_r + IDX_W'(1);
        if (fill_cnt_r == LAST_SLOT) begin
          first_r    <= FIRST_START;
          second_r   <= SECOND_START;
          warm_cnt_r <= '0;
        end
      end
      if (issue && state_r == ST_WARM) begin
        warm_cnt_r <= warm_cnt_r + WARM_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      wr_addr_r <= first_dn;
    end
    if (load_out) begin
      out_value_r <= draw_val;
    end
    if (in_fire && in_operation == OP_SEED) begin
      prev_r <= seed_sat;
      cur_r  <= VAL_W'(1);
      slot_r <= '0;
    end else if (state_r == ST_FILL) begin
      slot_r <= (slot_sum >= (IDX_W+1)'(RING_LEN)) ? IDX_W'(slot_sum - (IDX_W+1)'(RING_LEN))
                                                  : slot_sum[IDX_W-1:0];
      if (fill_cnt_r != '0) begin
        prev_r <= cur_r;
        cur_r  <= sub_mod(prev_r, cur_r, eff_mod);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

endmodule

`default_nettype wire

FILE: rtl/srg_checker.sv
// ----------------------------------------------------------------------------
// srg_checker
// Port-level checks of the subtractive random generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      in_operation,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [srg_pkg::VAL_W-1:0] out_random_value
);

  import srg_pkg::*;

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_value))
    else $error("result changed or dropped while stalled");

  // a seed transaction keeps the block busy
  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_SEED |=> !in_ready)
    else $error("input accepted right after a seed");

  // a draw transaction produces a result through the RAM read and the output register
  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_DRAW |-> ##2 out_valid)
    else $error("draw produced no result");

  // a seed transaction produces no result
  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_SEED && !out_valid |=> !out_valid)
    else $error("seed produced a result");

endmodule

bind subtractive_random_generator srg_checker u_srg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_random_value (out_random_value)
);

`default_nettype wire

FILE: sim/tb_subtractive_random_generator.sv
// ----------------------------------------------------------------------------
// tb_subtractive_random_generator
// Self-checking bench for the lag 55/24 subtractive generator. Draw and seed
// transactions go in over the input handshake while a local copy of the ring,
// its two indices and the modulus predicts every drawn value. Directed tests
// cover draws on the reset ring, seed saturation, modulus extremes and a
// modulus change after seeding. Random traffic and a long output stall follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_subtractive_random_generator;
  import srg_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 300;    // covers a whole seed
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned BATCHES       = 5;
  localparam int unsigned BATCH_ITEMS   = 100;
  localparam int unsigned SEED_PCT      = 6;
  localparam longint      RUN_LIMIT     = 64'd10_000_000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_operation = OP_DRAW;
  logic [VAL_W-1:0]  in_seed_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VAL_W-1:0]  out_random_value;
  logic              cfg_wr_en = 1'b0;
  logic [VAL_W-1:0]  cfg_wr_data = '0;

  // generator model
  logic [VAL_W-1:0]  ring_model [RING_LEN];
  logic [IDX_W-1:0]  lead_idx;
  logic [IDX_W-1:0]  lag_idx;
  logic [VAL_W-1:0]  modulus_reg;

  logic [VAL_W-1:0]  pending_values [$];
  logic [VAL_W-1:0]  oldest_value;
  int                fail_count = 0;
  int                send_idle_pct = 32;
  int                recv_idle_pct = 82;
  logic              recv_hold = 1'b0;

  subtractive_random_generator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [IDX_W-1:0] slot_below(input logic [IDX_W-1:0] idx);
    return (idx == '0 || idx > LAST_SLOT) ? LAST_SLOT : idx - IDX_W'(1);
  endfunction

  // difference mod m; a modulus below two acts as two, result wraps at 30 bits
  function automatic logic [VAL_W-1:0] mod_diff(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] m;
    m = (modulus_reg < MODULUS_MIN) ? MODULUS_MIN : modulus_reg;
    return (a >= b) ? a - b : a - b + m;
  endfunction

  function automatic logic [VAL_W-1:0] next_value();
    logic [VAL_W-1:0] v;
    lead_idx = slot_below(lead_idx);
    lag_idx  = slot_below(lag_idx);
    v = mod_diff(ring_model[lead_idx], ring_model[lag_idx]);
    ring_model[lead_idx] = v;
    return v;
  endfunction

  function automatic void reseed(input logic [VAL_W-1:0] seed);
    logic [VAL_W-1:0] m;
    logic [VAL_W-1:0] prev;
    logic [VAL_W-1:0] cur;
    logic [VAL_W-1:0] nxt;
    m = (modulus_reg < MODULUS_MIN) ? MODULUS_MIN : modulus_reg;
    if (seed > m - VAL_W'(1)) begin
      seed = m - VAL_W'(1);
    end
    ring_model[0] = seed;
    prev = seed;
    cur  = VAL_W'(1);
    for (int i = 1; i < RING_LEN; i++) begin
      ring_model[IDX_W'((int'(SCATTER_STRIDE) * i) % RING_LEN)] = cur;
      nxt  = mod_diff(prev, cur);
      prev = cur;
      cur  = nxt;
    end
    lead_idx = FIRST_START;
    lag_idx  = SECOND_START;
    for (int i = 0; i < WARM_DRAWS; i++) begin
      void'(next_value());
    end
  endfunction

  function automatic logic [VAL_W-1:0] pick_modulus();
    case ($urandom_range(0, 5))
      0:       return MODULUS_RESET;
      1:       return '1;
      2:       return VAL_W'($urandom_range(2, 64));
      3:       return VAL_W'($urandom_range(0, 1));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_seed();
    case ($urandom_range(0, 4))
      0:       return '1;
      1:       return VAL_W'($urandom_range(0, 3));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // random ready, forced low while a hold-off is running
  always @(posedge clk) begin
    if (recv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // outputs are stable at the falling edge; a transaction seen here
  // completes at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_values.size() == 0) begin
        $error("random_value %0d arrived with no draw outstanding", out_random_value);
        fail_count++;
      end else begin
        oldest_value = pending_values.pop_front();
        if (out_random_value !== oldest_value) begin
          $error("random_value mismatch: expected %0d, actual %0d",
                 oldest_value, out_random_value);
          fail_count++;
        end
      end
    end
  end

  // called and returns at a rising edge; valid stays up after the transaction
  // so back-to-back items need no second assignment in one step
  task automatic send_item(input logic op, input logic [VAL_W-1:0] seed);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_seed_value <= seed;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (op == OP_SEED) begin
      reseed(seed);
    end else begin
      pending_values.push_back(next_value());
    end
  endtask

  task automatic wait_idle();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_values.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_values.size() != 0) begin
      $error("%0d draw results never arrived", pending_values.size());
      fail_count++;
      pending_values.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [VAL_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    modulus_reg = value;
  endtask

  task automatic test_draw_before_seed();
    send_item(OP_DRAW, '1);
    send_item(OP_DRAW, '0);
  endtask

  task automatic test_seed_saturation();
    send_item(OP_SEED, '0);
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, '1);
    send_item(OP_SEED, '1);
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, '0);
    send_item(OP_SEED, MODULUS_RESET - VAL_W'(1));
    send_item(OP_DRAW, '0);
  endtask

  task automatic test_modulus_extremes();
    wait_idle();
    write_modulus('1);
    send_item(OP_SEED, '1);
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, '0);
    wait_idle();
    write_modulus(MODULUS_MIN);
    send_item(OP_SEED, VAL_W'(5));
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, '0);
    // moduli of zero and one behave as two
    wait_idle();
    write_modulus('0);
    send_item(OP_SEED, VAL_W'(1));
    send_item(OP_DRAW, '0);
    wait_idle();
    write_modulus(VAL_W'(1));
    send_item(OP_DRAW, '0);
  endtask

  task automatic test_modulus_change_after_seed();
    wait_idle();
    write_modulus('1);
    send_item(OP_SEED, VAL_W'(30'h2AAA_AAAA));
    // ring now holds entries far above the new modulus
    wait_idle();
    write_modulus(VAL_W'(3));
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, '0);
    wait_idle();
    write_modulus(MODULUS_RESET);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int b = 0; b < BATCHES; b++) begin
      wait_idle();
      write_modulus(pick_modulus());
      if ($urandom_range(0, 3) != 0) begin
        send_item(OP_SEED, pick_seed());
      end
      for (int n = 0; n < BATCH_ITEMS; n++) begin
        if ($urandom_range(0, 99) < SEED_PCT) begin
          send_item(OP_SEED, pick_seed());
        end else begin
          send_item(OP_DRAW, VAL_W'($urandom));
        end
      end
    end
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
      end
      begin
        for (int n = 0; n < 30; n++) begin
          send_item((n == 10) ? OP_SEED : OP_DRAW, VAL_W'($urandom));
        end
      end
    join
  endtask

  initial begin
    ring_model  = '{default: '0};
    lead_idx    = FIRST_START;
    lag_idx     = SECOND_START;
    modulus_reg = MODULUS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_draw_before_seed();
    test_seed_saturation();
    test_modulus_extremes();
    test_modulus_change_after_seed();
    test_random_traffic(32, 82);
    test_random_traffic(82, 32);
    test_random_traffic(0, 0);
    test_output_backpressure();

    wait_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/srg_pkg.sv
rtl/srg_ram.sv
rtl/subtractive_random_generator.sv
rtl/srg_checker.sv
sim/tb_subtractive_random_generator.sv
